[src/psit_pkg.sv]
// Shared types and constants for the paged sparse index table.
// Used by psit_dir, psit_store and the top level; no dependencies.
package psit_pkg;

    localparam int KEY_BITS      = 20;
    localparam int VAL_BITS      = 20;
    localparam int PAGE_ENTRIES  = 256;
    localparam int DIR_PAGES     = 4096;
    localparam int PHYS_PAGES    = 16;

    localparam int OFF_BITS      = $clog2(PAGE_ENTRIES);
    localparam int PG_BITS       = KEY_BITS - OFF_BITS;
    localparam int DIR_ADDR_BITS = $clog2(DIR_PAGES);
    localparam int PHYS_BITS     = $clog2(PHYS_PAGES);
    localparam int CNT_BITS      = $clog2(PHYS_PAGES + 1);
    localparam int STORE_ADDR_BITS = PHYS_BITS + OFF_BITS;
    localparam int STORE_DEPTH   = PHYS_PAGES * PAGE_ENTRIES;
    localparam int CLEAR_DEPTH   = (DIR_PAGES > STORE_DEPTH) ? DIR_PAGES : STORE_DEPTH;
    localparam int CLR_BITS      = $clog2(CLEAR_DEPTH);

    localparam logic [KEY_BITS-1:0] KEY_ONES = '1;
    localparam logic [VAL_BITS-1:0] VAL_ONES = '1;

    localparam logic [1:0] OP_GET = 2'd0;
    localparam logic [1:0] OP_SET = 2'd1;
    localparam logic [1:0] OP_DEL = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_INDEX = 2'd1;
    localparam logic [1:0] ST_BEYOND    = 2'd2;
    localparam logic [1:0] ST_NO_PAGE   = 2'd3;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_GET,
        ACT_SET,
        ACT_DEL
    } act_t;

    typedef struct packed {
        logic [1:0]          op;
        logic [KEY_BITS-1:0] key;
        logic [VAL_BITS-1:0] val;
    } req_t;

    typedef struct packed {
        act_t                       act;
        logic [1:0]                 status;
        logic [STORE_ADDR_BITS-1:0] addr;
        logic [VAL_BITS-1:0]        val;
    } stage_t;

    typedef struct packed {
        logic [VAL_BITS-1:0] read_value;
        logic                present;
        logic [1:0]          status;
    } res_t;

    typedef struct packed {
        logic                active;
        logic [CLR_BITS-1:0] addr;
    } clr_t;

endpackage

[src/paged_sparse_index_table.sv]
// Paged sparse index table, top level: clear sequencer, stage chain, output register.
// Depends on psit_pkg, psit_dir and psit_store.
// A result passes the input, store and output registers after its input transfer.
// Throughput: one transfer per cycle unless m_tready holds the output, set by the
// separate write and registered read ports of each memory with write forwarding.
// Reset: aresetn synchronous active low, then a clearing pass with s_tready low.
module paged_sparse_index_table
    import psit_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // key_index[19:0], write_value[39:20]
    input  logic [1:0]  s_tuser,   // opcode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // read_value[19:0], zero[23:20]
    output logic [2:0]  m_tuser    // present[0], status[2:1]
);

    logic                clearing_reg, clearing_next;
    logic [CLR_BITS-1:0] clr_cnt_reg, clr_cnt_next;
    clr_t                clr;

    req_t   req;
    logic   dir_in_ready;
    logic   dir_out_valid;
    stage_t dir_stage;
    logic   st_in_ready;
    logic   st_out_valid;
    res_t   st_res;

    logic   m_valid_reg, m_valid_next;
    res_t   m_res_reg;
    logic   out_ready;

    assign clr.active = clearing_reg;
    assign clr.addr   = clr_cnt_reg;

    always_comb begin
        clearing_next = clearing_reg;
        clr_cnt_next  = clr_cnt_reg;
        if (clearing_reg) begin
            clr_cnt_next = clr_cnt_reg + CLR_BITS'(1);
            if (clr_cnt_reg == CLR_BITS'(CLEAR_DEPTH - 1)) begin
                clearing_next = 1'b0;
            end
        end
    end

    assign req.op  = s_tuser;
    assign req.key = s_tdata[KEY_BITS-1:0];
    assign req.val = s_tdata[KEY_BITS +: VAL_BITS];

    assign s_tready  = dir_in_ready && !clearing_reg;
    assign out_ready = !m_valid_reg || m_tready;

    psit_dir u_dir (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .clr       (clr),
        .in_valid  (s_tvalid && s_tready),
        .in_req    (req),
        .in_ready  (dir_in_ready),
        .out_valid (dir_out_valid),
        .out_stage (dir_stage),
        .out_ready (st_in_ready)
    );

    psit_store u_store (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .clr       (clr),
        .in_valid  (dir_out_valid),
        .in_stage  (dir_stage),
        .in_ready  (st_in_ready),
        .out_valid (st_out_valid),
        .out_res   (st_res),
        .out_ready (out_ready)
    );

    assign m_valid_next = out_ready ? st_out_valid : m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            clearing_reg <= clearing_next;
            clr_cnt_reg  <= clr_cnt_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready) begin
            m_res_reg <= st_res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(24 - VAL_BITS)'(0), m_res_reg.read_value};
    assign m_tuser  = {m_res_reg.status, m_res_reg.present};

    a_no_accept_while_clearing : assert property (@(posedge aclk)
        clearing_reg |-> !s_tready)
        else $error("input accepted during clearing pass");

    a_reset_starts_clear : assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("input ready right after reset");

    a_present_only_ok : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tuser[2:1] == ST_OK && m_tdata[19:0] != VAL_ONES)
        else $error("present result with bad status or absent value");

    a_error_reads_absent : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[2:1] != ST_OK) |-> m_tdata[19:0] == VAL_ONES)
        else $error("failed request returned a value");

endmodule

[src/psit_dir.sv]
// Directory stage: page directory memory, free page counter and request decode.
// Depends on psit_pkg.
module psit_dir
    import psit_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  clr_t   clr,
    input  logic   in_valid,
    input  req_t   in_req,
    output logic   in_ready,
    output logic   out_valid,
    output stage_t out_stage,
    input  logic   out_ready
);

    typedef struct packed {
        logic                 mapped;
        logic [PHYS_BITS-1:0] phys;
    } dir_ent_t;

    dir_ent_t dir_mem [DIR_PAGES];

    logic                     v1_reg, v1_next;
    req_t                     req_reg;
    dir_ent_t                 rd_reg;
    logic [CNT_BITS-1:0]      free_reg, free_next;
    logic                     fwd_valid_reg, fwd_valid_next;
    logic [DIR_ADDR_BITS-1:0] fwd_addr_reg;
    dir_ent_t                 fwd_ent_reg;

    logic [PG_BITS-1:0]       pg;
    logic [OFF_BITS-1:0]      off;
    logic [DIR_ADDR_BITS-1:0] pg_addr;
    logic [DIR_ADDR_BITS-1:0] in_addr;
    dir_ent_t                 ent;
    logic                     in_dir;
    logic                     mapped;
    logic                     full;
    logic                     alloc;
    logic                     fire;
    logic [PHYS_BITS-1:0]     phys_sel;
    act_t                     act;
    logic [1:0]               status;

    assign in_ready = !v1_reg || out_ready;
    assign fire     = v1_reg && out_ready;
    assign in_addr  = in_req.key[OFF_BITS +: DIR_ADDR_BITS];

    assign pg      = req_reg.key[KEY_BITS-1:OFF_BITS];
    assign off     = req_reg.key[OFF_BITS-1:0];
    assign pg_addr = pg[DIR_ADDR_BITS-1:0];
    assign ent     = (fwd_valid_reg && fwd_addr_reg == pg_addr) ? fwd_ent_reg : rd_reg;
    assign in_dir  = {1'b0, pg} < (PG_BITS + 1)'(DIR_PAGES);
    assign mapped  = in_dir && ent.mapped;
    assign full    = free_reg >= CNT_BITS'(PHYS_PAGES);

    always_comb begin
        status   = ST_OK;
        act      = ACT_NONE;
        alloc    = 1'b0;
        phys_sel = ent.phys;
        if (req_reg.op <= OP_DEL) begin
            if (req_reg.key == KEY_ONES) begin
                status = ST_BAD_INDEX;
            end else begin
                unique case (req_reg.op)
                    OP_GET: begin
                        act = mapped ? ACT_GET : ACT_NONE;
                    end
                    OP_SET: begin
                        if (!in_dir) begin
                            status = ST_BEYOND;
                        end else if (!mapped) begin
                            if (full) begin
                                status = ST_NO_PAGE;
                            end else begin
                                alloc    = 1'b1;
                                phys_sel = free_reg[PHYS_BITS-1:0];
                                act      = ACT_SET;
                            end
                        end else begin
                            act = ACT_SET;
                        end
                    end
                    OP_DEL: begin
                        act = mapped ? ACT_DEL : ACT_NONE;
                    end
                    default: begin
                        act = ACT_NONE;
                    end
                endcase
            end
        end
    end

    assign out_valid        = v1_reg;
    assign out_stage.act    = act;
    assign out_stage.status = status;
    assign out_stage.addr   = {phys_sel, off};
    assign out_stage.val    = req_reg.val;

    always_comb begin
        v1_next        = in_ready ? in_valid : v1_reg;
        free_next      = free_reg;
        fwd_valid_next = fwd_valid_reg;
        if (fire && alloc) begin
            free_next      = free_reg + CNT_BITS'(1);
            fwd_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            free_reg      <= '0;
            fwd_valid_reg <= 1'b0;
        end else begin
            v1_reg        <= v1_next;
            free_reg      <= free_next;
            fwd_valid_reg <= fwd_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            req_reg <= in_req;
        end
        if (fire && alloc) begin
            fwd_addr_reg       <= pg_addr;
            fwd_ent_reg.mapped <= 1'b1;
            fwd_ent_reg.phys   <= free_reg[PHYS_BITS-1:0];
        end
    end

    // directory memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (clr.active) begin
            dir_mem[clr.addr[DIR_ADDR_BITS-1:0]] <= '0;
        end else if (fire && alloc) begin
            dir_mem[pg_addr] <= '{mapped: 1'b1, phys: free_reg[PHYS_BITS-1:0]};
        end
        if (in_ready) begin
            rd_reg <= dir_mem[in_addr];
        end
    end

endmodule

[src/psit_store.sv]
// Store stage: page store memory with per-entry written flag, get/set/delete access.
// Depends on psit_pkg.
module psit_store
    import psit_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  clr_t   clr,
    input  logic   in_valid,
    input  stage_t in_stage,
    output logic   in_ready,
    output logic   out_valid,
    output res_t   out_res,
    input  logic   out_ready
);

    typedef struct packed {
        logic                written;
        logic [VAL_BITS-1:0] value;
    } store_ent_t;

    store_ent_t store_mem [STORE_DEPTH];

    logic                       v2_reg, v2_next;
    stage_t                     stage_reg;
    store_ent_t                 rd_reg;
    logic                       fwd_valid_reg, fwd_valid_next;
    logic [STORE_ADDR_BITS-1:0] fwd_addr_reg;
    store_ent_t                 fwd_ent_reg;

    store_ent_t ent;
    store_ent_t wr_ent;
    logic       fire;
    logic       wr_en;

    assign in_ready = !v2_reg || out_ready;
    assign fire     = v2_reg && out_ready;
    assign wr_en    = fire && (stage_reg.act == ACT_SET || stage_reg.act == ACT_DEL);
    assign ent      = (fwd_valid_reg && fwd_addr_reg == stage_reg.addr) ? fwd_ent_reg : rd_reg;

    assign wr_ent.written = (stage_reg.act == ACT_SET);
    assign wr_ent.value   = stage_reg.val;

    always_comb begin
        out_res.read_value = VAL_ONES;
        out_res.present    = 1'b0;
        out_res.status     = stage_reg.status;
        if (stage_reg.act == ACT_GET && ent.written) begin
            out_res.read_value = ent.value;
            out_res.present    = (ent.value != VAL_ONES);
        end
    end

    assign out_valid = v2_reg;

    always_comb begin
        v2_next        = in_ready ? in_valid : v2_reg;
        fwd_valid_next = fwd_valid_reg | wr_en;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg        <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end else begin
            v2_reg        <= v2_next;
            fwd_valid_reg <= fwd_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            stage_reg <= in_stage;
        end
        if (wr_en) begin
            fwd_addr_reg <= stage_reg.addr;
            fwd_ent_reg  <= wr_ent;
        end
    end

    // page store memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (clr.active) begin
            store_mem[clr.addr[STORE_ADDR_BITS-1:0]] <= '0;
        end else if (wr_en) begin
            store_mem[stage_reg.addr] <= wr_ent;
        end
        if (in_ready) begin
            rd_reg <= store_mem[in_stage.addr];
        end
    end

endmodule
